// File: hw/rtl/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types and constants for the deque with cursor walk: request codes,
// move directions, and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DATA_W    = 32;
    localparam int ENTRIES_W = 7;

    typedef enum logic [2:0] {
        REQ_EMPTY  = 3'd0,
        REQ_SIZE   = 3'd1,
        REQ_PUSH_F = 3'd2,
        REQ_PUSH_B = 3'd3,
        REQ_POP_F  = 3'd4,
        REQ_POP_B  = 3'd5,
        REQ_DUMP   = 3'd6,
        REQ_MOVE   = 3'd7
    } req_t;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;

    // Controller to datapath
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic move;       // step the walk cursor
        logic end_walk;   // close the walk in progress
        logic rd_cursor;  // read the entry under the cursor
        logic rd_dump;    // read the entry at the dump index
        logic idx_clear;
        logic idx_inc;
        logic out_load;   // load the result register
        logic out_mem;    // result data comes from the read port
        logic out_ovf;
        logic out_last;
    } dwc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;   // result register can take a beat this cycle
        logic dump_last;  // dump index is on the back entry
    } dwc_sts_t;

endpackage

// File: hw/rtl/dwc_dp.sv
// ----------------------------------------------------------------------------
// dwc_dp
// Datapath: ring-buffer entry memory with registered read, front index,
// entry count, walk cursor, dump index and the result register.
// ----------------------------------------------------------------------------
module dwc_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dwc_pkg::dwc_cmd_t                   cmd,
    output dwc_pkg::dwc_sts_t                   sts,
    input  logic signed [dwc_pkg::DATA_W-1:0]   value,
    input  logic [1:0]                          direction,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [dwc_pkg::DATA_W-1:0]   data,
    output logic [dwc_pkg::ENTRIES_W-1:0]       entries,
    output logic                                is_empty,
    output logic                                overflow,
    output logic                                last
);
    import dwc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S  = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
            sum = sum - DEPTH_S;
        return sum[AW-1:0];
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic          walking_reg, walking_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     cur_base, cur_clamp;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic [CW-1:0]            out_count_reg, out_count_next;
    logic                     out_ovf_reg, out_ovf_next;
    logic                     out_last_reg, out_last_next;

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == DEPTH_C);
    assign sts.out_free  = !out_valid_reg || !rsp_stall;
    assign sts.dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        walking_next = walking_reg;
        idx_next     = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = slot(front_reg, AW'(count_reg));
        cur_base     = walking_reg ? cursor_reg : '0;
        cur_clamp    = cur_base;

        if (cmd.push_front)
        begin
            front_next = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
            wr_addr    = front_next;
            wr_en      = 1'b1;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.push_back)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front && count_reg != '0)
        begin
            front_next = slot(front_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_back && count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
        end

        // Walk: start from the front (or from the cursor while a walk is in progress), clamp into range, then step once
        if (cmd.move)
        begin
            walking_next = 1'b1;
            cursor_next  = cur_base;
            if (count_reg != '0)
            begin
                if (CW'(cur_base) >= count_reg)
                    cur_clamp = AW'(count_reg - CW'(1));
                cursor_next = cur_clamp;
                if (direction == DIR_RIGHT && (CW'(cur_clamp) + CW'(1)) < count_reg)
                    cursor_next = cur_clamp + AW'(1);
                else if (direction == DIR_LEFT && cur_clamp != '0)
                    cursor_next = cur_clamp - AW'(1);
            end
        end
        if (cmd.end_walk)
            walking_next = 1'b0;

        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + AW'(1);
    end

    assign rd_en   = cmd.rd_cursor || cmd.rd_dump;
    assign rd_addr = cmd.rd_cursor ? slot(front_reg, cursor_reg) : slot(front_reg, idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cmd.out_mem ? rd_data_reg : '0;
            out_count_next = count_reg;
            out_ovf_next   = cmd.out_ovf;
            out_last_next  = cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            walking_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            walking_reg   <= walking_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign entries   = ENTRIES_W'(out_count_reg);
    assign is_empty  = (out_count_reg == '0);
    assign overflow  = out_ovf_reg;
    assign last      = out_last_reg;

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_front || cmd.push_back) |-> !sts.full)
        else $error("push written while full");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_dump_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_dump |-> (CW'(idx_reg) < count_reg))
        else $error("dump read outside stored entries");

endmodule

// File: hw/rtl/dwc_ctrl.sv
// ----------------------------------------------------------------------------
// dwc_ctrl
// Controller: decodes requests, sequences walk reads and dump streaming,
// and paces intake against the result register.
// ----------------------------------------------------------------------------
module dwc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         req_type,
    input  logic               walk_end,
    input  dwc_pkg::dwc_sts_t  sts,
    output dwc_pkg::dwc_cmd_t  cmd
);
    import dwc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WREAD,
        S_WLOAD,
        S_DREAD,
        S_DLOAD
    } state_t;

    state_t state_reg, state_next;
    req_t   req;
    logic   load_now;
    logic   accept;

    assign req = req_t'(req_type);

    // Requests that put a beat into the result register at intake
    always_comb
    begin
        load_now = (req inside {REQ_EMPTY, REQ_SIZE})
                || ((req inside {REQ_PUSH_F, REQ_PUSH_B}) && sts.full)
                || (req == REQ_DUMP && sts.empty)
                || (req == REQ_MOVE && walk_end && sts.empty);
    end

    assign req_stall = (state_reg != S_IDLE) || (load_now && !sts.out_free);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.end_walk = (req != REQ_MOVE);
                    case (req)
                        REQ_EMPTY, REQ_SIZE:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                        end
                        REQ_PUSH_F, REQ_PUSH_B:
                        begin
                            if (sts.full)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_ovf  = 1'b1;
                                cmd.out_last = 1'b1;
                            end
                            else
                            begin
                                cmd.push_front = (req == REQ_PUSH_F);
                                cmd.push_back  = (req == REQ_PUSH_B);
                            end
                        end
                        REQ_POP_F: cmd.pop_front = !sts.empty;
                        REQ_POP_B: cmd.pop_back  = !sts.empty;
                        REQ_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_last = 1'b1;
                            end
                            else
                            begin
                                cmd.idx_clear = 1'b1;
                                state_next    = S_DREAD;
                            end
                        end
                        REQ_MOVE:
                        begin
                            cmd.move = 1'b1;
                            if (walk_end)
                            begin
                                cmd.end_walk = 1'b1;
                                if (sts.empty)
                                begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_last = 1'b1;
                                end
                                else
                                    state_next = S_WREAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WREAD:
            begin
                cmd.rd_cursor = 1'b1;
                state_next    = S_WLOAD;
            end
            S_WLOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_mem  = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DREAD:
            begin
                cmd.rd_dump = 1'b1;
                state_next  = S_DLOAD;
            end
            S_DLOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_mem  = 1'b1;
                    cmd.out_last = sts.dump_last;
                    if (sts.dump_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_DREAD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while a beat waits");

    a_walk_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WREAD |=> state_reg == S_WLOAD)
        else $error("walk read not followed by result load");

    a_dump_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DLOAD && sts.out_free && sts.dump_last) |=> state_reg == S_IDLE)
        else $error("dump did not end on the back entry");

endmodule

// File: hw/rtl/deque_with_cursor_walk.sv
// ----------------------------------------------------------------------------
// deque_with_cursor_walk
// Double-ended queue of signed 32-bit values in a ring buffer, with queries,
// pushes and pops at both ends, a front-to-back dump and a cursor walk.
// ----------------------------------------------------------------------------
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+-------------------------------------------
//  request  | req_valid | req_stall | req_type, value, direction, walk_end
//  result   | rsp_valid | rsp_stall | data, entries, is_empty, overflow, last
//
//  Push, pop and non-final moves complete at intake; queries and dropped
//  pushes place one beat in the result register at intake.
//  A final walk move on a non-empty deque goes through accept, memory read
//  and result load; on an empty deque it loads one beat at intake.
//  A dump of N entries runs accept, then a memory read and a result load per
//  entry, and holds req_stall high until the back entry has been loaded; a
//  dump of an empty deque loads one beat at intake.
//  Each result load waits while rsp_stall keeps a beat in the result register,
//  and req_stall also rises then for a request that loads a beat at intake.
//  Reset (rst_n low) empties the queue and ends any walk; the entry memory
//  itself is not cleared, since only entries inside the count are read.
//
module deque_with_cursor_walk #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [2:0]                          req_type,
    input  logic signed [dwc_pkg::DATA_W-1:0]   value,
    input  logic [1:0]                          direction,
    input  logic                                walk_end,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [dwc_pkg::DATA_W-1:0]   data,
    output logic [dwc_pkg::ENTRIES_W-1:0]       entries,
    output logic                                is_empty,
    output logic                                overflow,
    output logic                                last
);
    import dwc_pkg::*;

    dwc_cmd_t cmd;
    dwc_sts_t sts;

    // Controller: decode each beat, sequence reads, pace intake
    dwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .walk_end  (walk_end),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: ring memory, pointers, cursor and the result register
    dwc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .value     (value),
        .direction (direction),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .data      (data),
        .entries   (entries),
        .is_empty  (is_empty),
        .overflow  (overflow),
        .last      (last)
    );

endmodule
